// File: src/mlprq_pkg.sv
// Shared constants, result codes and controller/datapath interface types
// for the multilevel priority ready queue. No dependencies.
`default_nettype none

package mlprq_pkg;

    // sizing
    localparam int LEVELS      = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int TASK_BITS   = 8;

    localparam int LEVEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = LEVEL_W + PTR_W;

    // fixed field widths of the stream payload
    localparam int IN_LEVEL_W  = 3;
    localparam int IN_TASK_W   = 8;
    localparam int OUT_TASK_W  = 8;
    localparam int OUT_LEVEL_W = 3;
    localparam int STATUS_W    = 2;

    // request kinds
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FETCH  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic take;        // request accepted this cycle
        logic load_fetch;  // fetched task is on the memory read port
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic fetch_hit;   // current request is a fetch that finds a task
    } dp_stat_t;

endpackage

`default_nettype wire

// File: src/mlprq_ctrl.sv
// Controller state machine of the multilevel priority ready queue.
// Depends on mlprq_pkg for the command and status types.
`default_nettype none

module mlprq_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire mlprq_pkg::dp_stat_t  stat,
    output mlprq_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   take;

    assign take     = s_tvalid && s_tready_reg;
    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    // commands to the datapath
    always_comb
    begin
        cmd.take       = take;
        cmd.load_fetch = (state_reg == S_READ);
    end

    // state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    s_tready_reg <= 1'b1;
                    if (take)
                    begin
                        s_tready_reg <= 1'b0;
                        if (stat.fetch_hit)
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            state_reg    <= S_OUT;
                            m_tvalid_reg <= 1'b1;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg    <= S_OUT;
                    m_tvalid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg    <= S_IDLE;
                        m_tvalid_reg <= 1'b0;
                        s_tready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    m_tvalid_reg <= 1'b0;
                    s_tready_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/mlprq_dp.sv
// Datapath of the multilevel priority ready queue: per-level pointers and
// counts, the task store, level selection and the result register.
// Depends on mlprq_pkg.
`default_nettype none

module mlprq_dp (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire mlprq_pkg::ctrl_cmd_t                   cmd,
    output mlprq_pkg::dp_stat_t                         stat,
    input  wire logic                                   mode,
    input  wire logic [mlprq_pkg::IN_LEVEL_W-1:0]       level,
    input  wire logic [mlprq_pkg::IN_TASK_W-1:0]        task_id,
    output logic      [mlprq_pkg::OUT_TASK_W-1:0]       out_task,
    output logic      [mlprq_pkg::OUT_LEVEL_W-1:0]      out_level,
    output logic      [mlprq_pkg::STATUS_W-1:0]         status
);

    logic [mlprq_pkg::PTR_W-1:0]     head_reg  [mlprq_pkg::LEVELS];
    logic [mlprq_pkg::PTR_W-1:0]     tail_reg  [mlprq_pkg::LEVELS];
    logic [mlprq_pkg::COUNT_W-1:0]   count_reg [mlprq_pkg::LEVELS];
    logic [mlprq_pkg::TASK_BITS-1:0] mem       [2**mlprq_pkg::ADDR_W];
    logic [mlprq_pkg::TASK_BITS-1:0] rd_data_reg;

    logic [mlprq_pkg::OUT_TASK_W-1:0]  out_task_reg;
    logic [mlprq_pkg::OUT_LEVEL_W-1:0] out_level_reg;
    logic [mlprq_pkg::STATUS_W-1:0]    status_reg;

    logic [mlprq_pkg::LEVELS-1:0]  nonempty;
    logic                          any_ready;
    logic [mlprq_pkg::LEVEL_W-1:0] sel_lvl;
    logic [mlprq_pkg::LEVEL_W-1:0] ins_lvl;
    logic                          ins_ok;
    logic                          do_insert;
    logic                          do_fetch;
    logic [mlprq_pkg::ADDR_W-1:0]  wr_addr;
    logic [mlprq_pkg::ADDR_W-1:0]  rd_addr;

    // nonempty flags and highest-level pick
    always_comb
    begin
        any_ready = 1'b0;
        sel_lvl   = '0;
        for (int i = 0; i < mlprq_pkg::LEVELS; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
        end
        for (int i = 0; i < mlprq_pkg::LEVELS; i++)
        begin
            if (nonempty[i])
            begin
                any_ready = 1'b1;
                sel_lvl   = mlprq_pkg::LEVEL_W'(i);
            end
        end
    end

    // insert checks: level in range and level not full
    always_comb
    begin
        ins_lvl = mlprq_pkg::LEVEL_W'(level);
        ins_ok  = (32'(level) < mlprq_pkg::LEVELS) &&
                  (32'(count_reg[ins_lvl]) < mlprq_pkg::QUEUE_DEPTH);
    end

    assign do_insert      = cmd.take && (mode == mlprq_pkg::MODE_INSERT) && ins_ok;
    assign do_fetch       = cmd.take && (mode == mlprq_pkg::MODE_FETCH) && any_ready;
    assign stat.fetch_hit = (mode == mlprq_pkg::MODE_FETCH) && any_ready;
    assign wr_addr        = {ins_lvl, tail_reg[ins_lvl]};
    assign rd_addr        = {sel_lvl, head_reg[sel_lvl]};

    function automatic logic [mlprq_pkg::PTR_W-1:0] next_slot(
        input logic [mlprq_pkg::PTR_W-1:0] p
    );
        return (32'(p) == mlprq_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    // per-level pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mlprq_pkg::LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (do_insert)
        begin
            tail_reg[ins_lvl]  <= next_slot(tail_reg[ins_lvl]);
            count_reg[ins_lvl] <= count_reg[ins_lvl] + 1'b1;
        end
        else if (do_fetch)
        begin
            head_reg[sel_lvl]  <= next_slot(head_reg[sel_lvl]);
            count_reg[sel_lvl] <= count_reg[sel_lvl] - 1'b1;
        end
    end

    // task store, one write or one read per request
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            mem[wr_addr] <= mlprq_pkg::TASK_BITS'(task_id);
        end
        if (do_fetch)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            out_task_reg  <= '0;
            out_level_reg <= '0;
            if (mode == mlprq_pkg::MODE_INSERT)
            begin
                status_reg <= ins_ok ? mlprq_pkg::ST_DONE : mlprq_pkg::ST_DROPPED;
            end
            else if (any_ready)
            begin
                status_reg    <= mlprq_pkg::ST_DONE;
                out_level_reg <= mlprq_pkg::OUT_LEVEL_W'(sel_lvl);
            end
            else
            begin
                status_reg <= mlprq_pkg::ST_EMPTY;
            end
        end
        else if (cmd.load_fetch)
        begin
            out_task_reg <= mlprq_pkg::OUT_TASK_W'(rd_data_reg);
        end
    end

    assign out_task  = out_task_reg;
    assign out_level = out_level_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// File: src/multilevel_priority_ready_queue.sv
// Strict-priority multilevel ready queue: one task FIFO per priority level,
// insert appends to a level, fetch pops the highest nonempty level. An insert
// request, or a fetch that finds nothing, returns its result in the cycle
// after acceptance. A fetch that finds a task passes through a read state
// first, because the task store has a registered read port. The block handles
// one request at a time, so the next request is taken no earlier than the
// cycle after the previous result is accepted downstream. Each request yields
// exactly one result; status 0 = done, 1 = nothing ready, 2 = insert dropped
// because the level is full. The store needs no clearing after reset. Built
// from mlprq_ctrl and mlprq_dp, types from mlprq_pkg.
`default_nettype none

module multilevel_priority_ready_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // level[2:0], task_id[10:3], zero pad
    input  wire logic [0:0]  s_tuser,   // mode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // out_task[7:0], out_level[10:8], zero pad
    output logic      [1:0]  m_tuser    // status[1:0]
);

    mlprq_pkg::ctrl_cmd_t cmd;
    mlprq_pkg::dp_stat_t  stat;

    logic [mlprq_pkg::OUT_TASK_W-1:0]  out_task;
    logic [mlprq_pkg::OUT_LEVEL_W-1:0] out_level;
    logic [mlprq_pkg::STATUS_W-1:0]    status;

    // sequencing of requests and results
    mlprq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // queues, level pick and result register
    mlprq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .mode      (s_tuser[0]),
        .level     (s_tdata[2:0]),
        .task_id   (s_tdata[10:3]),
        .out_task  (out_task),
        .out_level (out_level),
        .status    (status)
    );

    // result packing
    assign m_tdata = {5'd0, out_level, out_task};
    assign m_tuser = status;

endmodule

`default_nettype wire
